FILE: src/ntok_pkg.sv
// Package for the nested quote tokenizer: shared types and constants.
// No dependencies; every module of the tokenizer imports it.
`timescale 1ns / 1ps

package ntok_pkg;

    localparam int CHAR_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_PAIRS   = 4;    // pairs that fit in the 32-bit registers
    localparam int PAIR_CNT_W  = 3;

    localparam logic [CHAR_W-1:0] BACKSLASH = 8'h5C;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_OPEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_CLOSE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT = 3'd3;

    localparam logic [CHAR_W-1:0]     RST_DELIM = 8'd44;

    // Stack command for one accepted word
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_op_t;

    // Stack status seen by the control logic
    typedef struct packed {
        logic [CHAR_W-1:0] top_char;
        logic              empty;
        logic              full;
    } stack_stat_t;

endpackage

FILE: src/nested_quote_tokenizer.sv
// Nested quote tokenizer, top level. Holds the input and result registers,
// the token control state and the configuration registers.
// Depends on ntok_pkg, ntok_pair_match and ntok_stack.
`timescale 1ns / 1ps

// Splits a character stream into tokens on a configurable delimiter, one
// character word per clock. Up to MAX_PAIRS open/close pairs nest on a
// STACK_DEPTH deep stack; inside a pair the delimiter is kept and a
// backslash passes the following character through untouched. Each token
// character comes out with char_valid set; token_end marks the last word of
// a token (a delimiter that closes a token yields a word with char_valid
// low). Delimiters with no open token produce no output word at all.
// Throughput is one input word per cycle unless a word with a result waits
// on a stalled result register. The input register is loaded when a word is
// accepted and the result register when that word is processed; the
// per-character work (pair compares, stack top lookup and stack update) fits
// between those two registers, so the stack state is current for the very
// next word. The result register decouples the sides: a new word is taken
// while a finished one waits on out_ready.
// Configuration writes (cfg_index 0: delimiter, 1: open chars, 2: close
// chars, 3: pair count) are always accepted and must only be issued while
// the block is idle; unknown indexes are dropped. nest_overflow is sticky
// until reset.

module nested_quote_tokenizer #(
    parameter int STACK_DEPTH = 8,
    parameter int MAX_PAIRS   = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ntok_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ntok_pkg::CFG_DATA_W-1:0] cfg_data,
    // input characters
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ntok_pkg::CHAR_W-1:0]     in_char,
    input  logic                            last_char,
    // token output
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ntok_pkg::CHAR_W-1:0]     out_char,
    output logic                            char_valid,
    output logic                            token_end,
    output logic                            nest_overflow
);
    import ntok_pkg::*;

    // configuration
    logic [CHAR_W-1:0]     delim_reg;
    logic [CFG_DATA_W-1:0] open_reg;
    logic [CFG_DATA_W-1:0] close_reg;
    logic [PAIR_CNT_W-1:0] npairs_reg;

    // input register
    logic                  in_vld_reg;
    logic [CHAR_W-1:0]     in_char_reg;
    logic                  in_last_reg;

    // token state
    logic                  skip_reg;
    logic                  skip_next;
    logic                  tok_open_reg;
    logic                  tok_open_next;
    logic                  ovf_reg;
    logic                  ovf_next;

    // result register
    logic                  out_vld_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic                  out_cv_reg;
    logic                  out_end_reg;
    logic                  out_ovf_reg;

    logic                  res_valid;
    logic                  res_end;
    logic                  has_res;
    logic                  match_en;
    logic                  advance;
    logic                  push_raw;
    logic                  pop_raw;
    stack_op_t             st_op;
    stack_stat_t           st_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg  <= RST_DELIM;
            open_reg   <= '0;
            close_reg  <= '0;
            npairs_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DELIM:      delim_reg  <= cfg_data[CHAR_W-1:0];
                CFG_PAIR_OPEN:  open_reg   <= cfg_data;
                CFG_PAIR_CLOSE: close_reg  <= cfg_data;
                CFG_PAIR_COUNT: npairs_reg <= cfg_data[PAIR_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-word decision: escape pass-through, backslash inside a pair,
    // ordinary token character, or a delimiter outside all pairs; then the end-of-string close.
    always_comb
    begin
        res_valid     = 1'b0;
        res_end       = 1'b0;
        match_en      = 1'b0;
        skip_next     = skip_reg;
        tok_open_next = tok_open_reg;
        if (skip_reg)
        begin
            skip_next     = 1'b0;
            tok_open_next = 1'b1;
            res_valid     = 1'b1;
        end
        else if (!st_stat.empty && in_char_reg == BACKSLASH)
        begin
            skip_next     = 1'b1;
            tok_open_next = 1'b1;
            res_valid     = 1'b1;
        end
        else if (in_char_reg != delim_reg || !st_stat.empty)
        begin
            tok_open_next = 1'b1;
            res_valid     = 1'b1;
            match_en      = 1'b1;
        end
        else if (tok_open_reg)
        begin
            tok_open_next = 1'b0;
            res_end       = 1'b1;
        end
        // End of string: close any open token and drop all nesting
        if (in_last_reg)
        begin
            if (tok_open_next)
                res_end = 1'b1;
            skip_next     = 1'b0;
            tok_open_next = 1'b0;
        end
    end

    ntok_pair_match #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_match (
        .enable     (match_en),
        .char_in    (in_char_reg),
        .stat       (st_stat),
        .pair_open  (open_reg),
        .pair_close (close_reg),
        .pair_count (npairs_reg),
        .push       (push_raw),
        .pop        (pop_raw)
    );

    assign has_res  = res_valid || res_end;
    // Words with no result never wait on the output side
    assign advance  = in_vld_reg && (!has_res || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign ovf_next = ovf_reg || (push_raw && st_stat.full);

    assign st_op.push  = advance && push_raw;
    assign st_op.pop   = advance && pop_raw;
    assign st_op.clear = advance && in_last_reg;

    ntok_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (st_op),
        .push_char (in_char_reg),
        .stat      (st_stat)
    );

    // input register: hold until the word is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_char_reg <= in_char;
            in_last_reg <= last_char;
        end
    end

    // token state: advance once per processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg     <= 1'b0;
            tok_open_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else if (advance)
        begin
            skip_reg     <= skip_next;
            tok_open_reg <= tok_open_next;
            ovf_reg      <= ovf_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance && has_res)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_res)
        begin
            out_char_reg <= res_valid ? in_char_reg : '0;
            out_cv_reg   <= res_valid;
            out_end_reg  <= res_end;
            out_ovf_reg  <= ovf_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign out_char      = out_char_reg;
    assign char_valid    = out_cv_reg;
    assign token_end     = out_end_reg;
    assign nest_overflow = out_ovf_reg;

endmodule

FILE: src/ntok_pair_match.sv
// Pair matcher: compares one character against the configured open/close
// pairs and the stack top. Depends on ntok_pkg.
`timescale 1ns / 1ps

module ntok_pair_match #(
    parameter int MAX_PAIRS = 4
) (
    input  logic                                enable,
    input  logic [ntok_pkg::CHAR_W-1:0]         char_in,
    input  ntok_pkg::stack_stat_t               stat,
    input  logic [ntok_pkg::CFG_DATA_W-1:0]     pair_open,
    input  logic [ntok_pkg::CFG_DATA_W-1:0]     pair_close,
    input  logic [ntok_pkg::PAIR_CNT_W-1:0]     pair_count,
    output logic                                push,
    output logic                                pop
);
    import ntok_pkg::*;

    localparam int PAD_PAIRS = (MAX_PAIRS > CFG_PAIRS) ? MAX_PAIRS : CFG_PAIRS;
    localparam int PAD_W     = CHAR_W * PAD_PAIRS;

    logic [PAD_W-1:0] open_ext;
    logic [PAD_W-1:0] close_ext;

    // Pairs past the register width read as character zero
    assign open_ext  = PAD_W'(pair_open);
    assign close_ext = PAD_W'(pair_close);

    always_comb
    begin
        logic              done;
        logic [CHAR_W-1:0] op_c;
        logic [CHAR_W-1:0] cl_c;
        logic              pair_en;
        done = 1'b0;
        push = 1'b0;
        pop  = 1'b0;
        for (int i = 0; i < MAX_PAIRS; i++)
        begin
            op_c    = open_ext[CHAR_W*i +: CHAR_W];
            cl_c    = close_ext[CHAR_W*i +: CHAR_W];
            pair_en = ({1'b0, pair_count} > 4'(i));
            if (enable && pair_en && !done)
            begin
                if (!stat.empty && char_in == cl_c && op_c == stat.top_char)
                begin
                    pop  = 1'b1;
                    done = 1'b1;
                end
                else if (char_in == op_c)
                begin
                    push = 1'b1;
                    done = 1'b1;
                end
            end
        end
    end

endmodule

FILE: src/ntok_stack.sv
// Nesting stack: open characters of the open pairs and the fill level.
// Depends on ntok_pkg.
`timescale 1ns / 1ps

module ntok_stack #(
    parameter int STACK_DEPTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ntok_pkg::stack_op_t         op,
    input  logic [ntok_pkg::CHAR_W-1:0] push_char,
    output ntok_pkg::stack_stat_t       stat
);
    import ntok_pkg::*;

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [CHAR_W-1:0] stack_mem [STACK_DEPTH];
    logic [LVL_W-1:0]  level_reg;
    logic [LVL_W-1:0]  level_next;
    logic [LVL_W-1:0]  level_m1;
    logic              full;

    assign full     = (level_reg == LVL_W'(STACK_DEPTH));
    assign level_m1 = level_reg - LVL_W'(1);

    // Top entry is only looked at while the level is nonzero
    assign stat.top_char = stack_mem[level_m1[IDX_W-1:0]];
    assign stat.empty    = (level_reg == '0);
    assign stat.full     = full;

    always_comb
    begin
        level_next = level_reg;
        if (op.clear)
            level_next = '0;
        else if (op.pop)
            level_next = level_m1;
        else if (op.push && !full)
            level_next = level_reg + LVL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else
            level_reg <= level_next;
    end

    always_ff @(posedge clk)
    begin
        if (op.push && !full)
            stack_mem[level_reg[IDX_W-1:0]] <= push_char;
    end

endmodule

FILE: src/ntok_checker.sv
// Port-level checker for the nested quote tokenizer, bound to the top level.
// Depends on ntok_pkg and nested_quote_tokenizer.
`timescale 1ns / 1ps

module ntok_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [ntok_pkg::CHAR_W-1:0]     out_char,
    input  logic                            char_valid,
    input  logic                            token_end,
    input  logic                            nest_overflow
);
    import ntok_pkg::*;

    logic ovf_seen_reg;

    // remember an overflow once it has been delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovf_seen_reg <= 1'b0;
        else if (out_valid && out_ready && nest_overflow)
            ovf_seen_reg <= 1'b1;
    end

    // A stalled result word holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) &&
            $stable(char_valid) && $stable(token_end) && $stable(nest_overflow))
        else $error("result word changed while stalled");

    // Every word carries a character, a token end, or both
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> char_valid || token_end)
        else $error("empty result word");

    // Delimiter-only words carry a zero character
    a_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> out_char == '0)
        else $error("non-character word with nonzero char");

    // With the result slot empty the input side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // Overflow is sticky across words
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ovf_seen_reg |-> nest_overflow)
        else $error("overflow flag dropped");

endmodule

bind nested_quote_tokenizer ntok_checker u_ntok_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .char_valid    (char_valid),
    .token_end     (token_end),
    .nest_overflow (nest_overflow)
);

FILE: tb/tb_nested_quote_tokenizer.sv
// Self-checking testbench for nested_quote_tokenizer: directed and random character strings,
// a cycle-free predictor of the token words, and random stalls on both handshakes.
// Depends on ntok_pkg and the nested_quote_tokenizer RTL.
`timescale 1ns / 1ps

module tb_nested_quote_tokenizer;

    import ntok_pkg::*;

    localparam int STK_DEPTH  = 8;
    localparam int NUM_PAIRS  = 4;
    // Settle time after the last word: two register stages plus margin for
    // characters that produce no word at all.
    localparam int SETTLE     = 8;
    localparam int HOLD_OFF   = 300;    // long receiver stall to back up the input
    localparam int WDOG_LIMIT = 5000;   // cycles without any handshake

    // Register indexes beyond the map; writes to these must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Standard pair setup: pair 0 is '"' both ways, then (), [], {}
    localparam logic [31:0] STD_OPEN  = 32'h7B5B2822;
    localparam logic [31:0] STD_CLOSE = 32'h7D5D2922;
    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_LPAR   = 8'h28;
    localparam logic [7:0]  CH_RPAR   = 8'h29;
    localparam logic [7:0]  CH_LBRK   = 8'h5B;
    localparam logic [7:0]  CH_RBRK   = 8'h5D;
    localparam logic [7:0]  CH_LBRACE = 8'h7B;
    localparam logic [7:0]  CH_SEMI   = 8'h3B;

    // One output word as the block presents it
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              cv;
        logic              te;
        logic              ovf;
    } tok_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [CHAR_W-1:0]     in_char;
    logic                  last_char;
    logic                  out_valid;
    logic                  out_ready;
    logic [CHAR_W-1:0]     out_char;
    logic                  char_valid;
    logic                  token_end;
    logic                  nest_overflow;

    nested_quote_tokenizer #(
        .STACK_DEPTH (STK_DEPTH),
        .MAX_PAIRS   (NUM_PAIRS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_char       (in_char),
        .last_char     (last_char),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .token_end     (token_end),
        .nest_overflow (nest_overflow)
    );

    // Shadow copy of the configuration registers
    logic [7:0]  cur_delim;
    logic [31:0] cur_open;
    logic [31:0] cur_close;
    logic [2:0]  cur_count;

    // Shadow copy of the tokenizer state
    logic [7:0]  tok_stack [STK_DEPTH];
    int          tok_level;
    bit          tok_skip;
    bit          tok_open;
    bit          tok_ovf;

    // Words still owed by the block, oldest first
    tok_word_t   token_words_q[$];

    // Knobs shared between the test sequence and the handshake processes
    bit          src_idle_on;
    bit          sink_idle_on;
    bit          hold_req;
    bit          offering;

    int          n_errors;
    int          n_chars;
    int          n_strings;
    int          n_words;
    int          n_cfg;
    int          idle_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int active_pairs();
        return (cur_count > NUM_PAIRS) ? NUM_PAIRS : int'(cur_count);
    endfunction

    // Walk the pairs in order; the first pair that closes the innermost
    // open pair or opens a new one ends the walk.
    task automatic match_pairs(input logic [7:0] c);
        int         i;
        bit         done;
        logic [7:0] op;
        logic [7:0] cl;
        done = 1'b0;
        for (i = 0; i < active_pairs(); i++)
        begin
            op = cur_open[8*i +: 8];
            cl = cur_close[8*i +: 8];
            if (!done && tok_level != 0 && c == cl && op == tok_stack[tok_level-1])
            begin
                tok_level--;
                done = 1'b1;
            end
            if (!done && c == op)
            begin
                if (tok_level < STK_DEPTH)
                begin
                    tok_stack[tok_level] = op;
                    tok_level++;
                end
                else
                begin
                    tok_ovf = 1'b1;    // full stack: drop the push, flag it
                end
                done = 1'b1;
            end
        end
    endtask

    // Advance the shadow state by one accepted character and queue the
    // word it produces, if any.
    task automatic tokenize_char(input logic [7:0] c, input bit last);
        bit        valid;
        bit        tend;
        tok_word_t w;
        valid = 1'b0;
        tend  = 1'b0;
        if (tok_skip)
        begin
            // escaped character: pass through unchecked
            tok_skip = 1'b0;
            tok_open = 1'b1;
            valid    = 1'b1;
        end
        else if (tok_level != 0 && c == BACKSLASH)
        begin
            tok_skip = 1'b1;
            tok_open = 1'b1;
            valid    = 1'b1;
        end
        else if (c != cur_delim || tok_level != 0)
        begin
            tok_open = 1'b1;
            valid    = 1'b1;
            match_pairs(c);
        end
        else if (tok_open)
        begin
            tok_open = 1'b0;
            tend     = 1'b1;
        end
        if (last)
        begin
            if (tok_open)
                tend = 1'b1;
            tok_level = 0;
            tok_skip  = 1'b0;
            tok_open  = 1'b0;
        end
        if (valid || tend)
        begin
            w.ch  = valid ? c : 8'h00;
            w.cv  = valid;
            w.te  = tend;
            w.ovf = tok_ovf;
            token_words_q.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Offer one character and hold it until the block takes it. Keep valid
    // high into the next call unless an idle burst is drawn.
    task automatic send_char(input logic [7:0] c, input bit last);
        in_valid  <= 1'b1;
        in_char   <= c;
        last_char <= last;
        offering  = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tokenize_char(c, last);
        n_chars++;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Drop the input, wait for every owed word, then let the pipeline
    // flush characters that produce nothing.
    task automatic wait_idle();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (token_words_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DELIM:      cur_delim = val[7:0];
            CFG_PAIR_OPEN:  cur_open  = val;
            CFG_PAIR_CLOSE: cur_close = val;
            CFG_PAIR_COUNT: cur_count = val[2:0];
            default:        ;
        endcase
        n_cfg++;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] delim, input logic [31:0] op,
                              input logic [31:0] cl, input logic [2:0] cnt);
        wait_idle();
        write_reg(CFG_DELIM, {24'h0, delim});
        write_reg(CFG_PAIR_OPEN, op);
        write_reg(CFG_PAIR_CLOSE, cl);
        write_reg(CFG_PAIR_COUNT, {29'h0, cnt});
    endtask

    // Draw a character that steers the tokenizer: mostly delimiters, pair
    // characters that match the current nesting, and escapes.
    function automatic logic [7:0] pick_char();
        int         r;
        int         n;
        int         i;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        n = active_pairs();
        c = 8'($urandom_range(8'h61, 8'h7A));
        if (r >= 25 && r < 40)
        begin
            c = 8'($urandom_range(0, 255));
        end
        else if (r >= 40 && r < 55)
        begin
            c = cur_delim;
        end
        else if (r >= 55 && r < 70 && n > 0)
        begin
            c = cur_open[8*$urandom_range(0, n-1) +: 8];
        end
        else if (r >= 70 && r < 85 && n > 0)
        begin
            c = cur_close[8*$urandom_range(0, n-1) +: 8];
            // prefer the close that pops the innermost pair
            if (tok_level != 0)
            begin
                for (i = n - 1; i >= 0; i--)
                begin
                    if (cur_open[8*i +: 8] == tok_stack[tok_level-1])
                        c = cur_close[8*i +: 8];
                end
            end
        end
        else if (r >= 85 && r < 95)
        begin
            c = BACKSLASH;
        end
        else if (r >= 95)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Send whole strings until at least n_items characters went in.
    task automatic run_strings(input int n_items);
        int  start;
        int  len;
        int  i;
        bit  noisy;
        start = n_chars;
        while (n_chars - start < n_items)
        begin
            len   = $urandom_range(1, 16);
            noisy = ($urandom_range(0, 99) < 15);
            for (i = 0; i < len; i++)
                send_char(noisy ? 8'($urandom_range(0, 255)) : pick_char(), i == len - 1);
            n_strings++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Drive out_ready: a long hold-off once on request, otherwise random
    // stall bursts while idling is on.
    initial
    begin : sink_proc
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (sink_idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare every accepted word with the oldest owed one, field by field.
    always @(posedge clk)
    begin : word_check
        tok_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (token_words_q.size() == 0)
            begin
                report("word with nothing owed, out_char", 32'(out_char), 32'h0);
            end
            else
            begin
                w = token_words_q.pop_front();
                n_words++;
                if (out_char !== w.ch)
                    report("out_char", 32'(out_char), 32'(w.ch));
                if (char_valid !== w.cv)
                    report("char_valid", 32'(char_valid), 32'(w.cv));
                if (token_end !== w.te)
                    report("token_end", 32'(token_end), 32'(w.te));
                if (nest_overflow !== w.ovf)
                    report("nest_overflow", 32'(nest_overflow), 32'(w.ovf));
            end
        end
    end

    // End the run when no channel has moved a word for too long.
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d words still owed",
                     idle_cycles, token_words_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset config: comma delimiter, no pairs. Leading delimiter, a
    // closing delimiter, and a delimiter flagged last with no token open.
    task automatic test_default_delim();
        send_char(RST_DELIM, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(RST_DELIM, 1'b0);
        send_char(RST_DELIM, 1'b1);
    endtask

    // Four pairs: nesting, a close that does not match the top, an escape
    // inside a pair, a backslash outside pairs, a pair with equal open and
    // close characters, and a token ended by the last flag.
    task automatic test_pair_nesting();
        wait_idle();
        write_reg(CFG_SPARE_LO, 32'hFFFFFFFF);
        write_reg(CFG_SPARE_HI, 32'h00000000);
        write_reg(CFG_PAIR_OPEN, STD_OPEN);
        write_reg(CFG_PAIR_CLOSE, STD_CLOSE);
        write_reg(CFG_PAIR_COUNT, 32'd4);
        send_char(CH_LPAR, 1'b0);
        send_char(RST_DELIM, 1'b0);    // kept inside the pair
        send_char(CH_LBRK, 1'b0);
        send_char(CH_RPAR, 1'b0);      // top is '[': plain character
        send_char(BACKSLASH, 1'b0);
        send_char(CH_RBRK, 1'b0);      // escaped: no pop
        send_char(CH_RBRK, 1'b0);
        send_char(CH_RPAR, 1'b0);
        send_char(BACKSLASH, 1'b0);    // outside pairs: plain character
        send_char(RST_DELIM, 1'b0);
        send_char(CH_QUOTE, 1'b0);
        send_char(CH_QUOTE, 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    // Pair count above the limit, delimiter at its top value, and nine
    // opens into an eight-deep stack; end the string with an escape pending.
    task automatic test_stack_overflow();
        int i;
        wait_idle();
        write_reg(CFG_DELIM, 32'h000000FF);
        write_reg(CFG_PAIR_COUNT, 32'd7);
        for (i = 0; i < STK_DEPTH + 1; i++)
            send_char(CH_LBRACE, 1'b0);
        send_char(BACKSLASH, 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    // Standard pairs with random stalls; in the middle back up the block
    // with a long receiver hold-off, then pause the sender until drained.
    task automatic test_random_standard();
        set_config(RST_DELIM, STD_OPEN, STD_CLOSE, 3'd4);
        run_strings(60);
        src_idle_on = 1'b0;
        hold_req    = 1'b1;
        run_strings(40);
        src_idle_on = 1'b1;
        wait_idle();
        run_strings(60);
    endtask

    // Extreme register values: all-ones opens with all-zero closes, then
    // the reverse with no pairs in use.
    task automatic test_extreme_config();
        set_config(8'h00, 32'hFFFFFFFF, 32'h00000000, 3'd7);
        run_strings(70);
        set_config(8'hFF, 32'h00000000, 32'hFFFFFFFF, 3'd0);
        run_strings(60);
    endtask

    task automatic test_random_configs();
        int k;
        for (k = 0; k < 3; k++)
        begin
            set_config(8'($urandom_range(0, 255)), $urandom, $urandom,
                       3'($urandom_range(0, 7)));
            run_strings(80);
        end
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_full_rate();
        set_config(CH_SEMI, STD_OPEN, STD_CLOSE, 3'd2);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_strings(100);
    endtask

    initial
    begin : main_seq
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_char      = '0;
        last_char    = 1'b0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_req     = 1'b0;
        offering     = 1'b0;
        n_errors     = 0;
        n_chars      = 0;
        n_strings    = 0;
        n_words      = 0;
        n_cfg        = 0;
        cur_delim    = RST_DELIM;
        cur_open     = '0;
        cur_close    = '0;
        cur_count    = '0;
        tok_level    = 0;
        tok_skip     = 1'b0;
        tok_open     = 1'b0;
        tok_ovf      = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_delim();
        test_pair_nesting();
        test_stack_overflow();
        test_random_standard();
        test_extreme_config();
        test_random_configs();
        test_full_rate();

        // drain and let the pipeline settle; the watchdog bounds this
        wait_idle();

        $display("Run covered %0d characters in %0d random strings plus directed cases,",
                 n_chars, n_strings);
        $display("%0d token words checked over %0d register writes", n_words, n_cfg);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/ntok_pkg.sv
src/ntok_pair_match.sv
src/ntok_stack.sv
src/nested_quote_tokenizer.sv
src/ntok_checker.sv
tb/tb_nested_quote_tokenizer.sv
